>>> rtl/apba_pkg.sv
package apba_pkg;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 9;
  localparam int BIAS_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // bitmap organisation: 32-bit words, at most 256 live entries
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int IDX_W    = 8;
  localparam int ROW_BITS = IDX_W - BIT_W;
  localparam int MAX_LIVE = 2 ** IDX_W;

  // entries held by the pool bitmap
  localparam int POOL_ENTRIES = 256;

  typedef enum logic [1:0] {
    OP_REQUEST   = 2'd0,
    OP_FREE      = 2'd1,
    OP_CHECK     = 2'd2,
    OP_SET_STATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCATE,
    S_READ,
    S_EVAL
  } fsm_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BIAS = 2'd2;

  // configuration reset values
  localparam logic [ADDR_W-1:0] NETWORK_BASE_RST = 32'd0;
  localparam logic [CNT_W-1:0]  POOL_COUNT_RST   = 9'd256;
  localparam logic [BIAS_W-1:0] ADDRESS_BIAS_RST = 2'd1;

  // lowest clear bit of a word: {found, position}
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] res;
    res = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) begin
        res = {1'b1, BIT_W'(b)};
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/apba_ram.sv
module apba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/address_pool_bitmap_allocator.sv
// channel  direction  transfer when          payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid & in_ready    in_operation, in_address, in_new_state
// out      out        out_valid & out_ready  out_status, out_granted_address, out_in_use
//
// One item at a time. Free, check and set state pass through accept, range check,
// bitmap word read and evaluate, with a write back for set state and for a free of a
// used entry. A request reads and evaluates the 32-bit bitmap words in turn (1 to 8 of
// them) in the single-port word read and evaluate loop. An out-of-range address finishes at the range check.
// Reset clears every row valid bit at once, so the bitmap reads as all free; no
// clearing pass. A held result stalls the final step only; in_ready returns with idle.
module address_pool_bitmap_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apba_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [apba_pkg::ADDR_W-1:0]         in_address,
  input  logic                                in_new_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [apba_pkg::ADDR_W-1:0]         out_granted_address,
  output logic                                out_in_use
);

  import apba_pkg::*;

  localparam int LIVE_ENTRIES = POOL_ENTRIES < MAX_LIVE ? POOL_ENTRIES : MAX_LIVE;
  localparam int NUM_WORDS    = (LIVE_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int ROW_AW       = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam logic [CNT_W-1:0] LIVE_LIMIT = CNT_W'(LIVE_ENTRIES);

  // configuration registers
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  count_r;
  logic [BIAS_W-1:0] bias_r;
  logic [CNT_W-1:0]  live_count;

  // item context
  fsm_t              state_r, state_nxt;
  op_t               op_r;
  logic              new_state_r;
  logic [ADDR_W:0]   diff_r;
  logic [ADDR_W-1:0] base_bias_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ROW_BITS-1:0] word_r, word_nxt;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_granted_r;
  logic              out_in_use_r;

  // bitmap memory and row valid bits
  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_q;
  logic [NUM_WORDS-1:0] row_valid_r;
  logic [WORD_W-1:0] rd_word;

  // per-step working signals
  logic              out_free;
  logic              load_out;
  status_t           res_status;
  logic [ADDR_W-1:0] res_granted;
  logic              res_in_use;
  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] eff;
  logic              out_of_range;
  logic [WORD_W-1:0] usable;
  logic [WORD_W-1:0] taken;
  logic [BIT_W:0]    zero_hit;
  logic [ROW_BITS:0] word_inc;
  logic [CNT_W-1:0]  next_base;
  logic [WORD_W-1:0] bit_mask;
  logic              cur_bit;

  apba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= NETWORK_BASE_RST;
      count_r <= POOL_COUNT_RST;
      bias_r  <= ADDRESS_BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NETWORK_BASE: base_r  <= cfg_data;
        CFG_POOL_COUNT:   count_r <= cfg_data[CNT_W-1:0];
        CFG_ADDRESS_BIAS: bias_r  <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign live_count = count_r < LIVE_LIMIT ? count_r : LIVE_LIMIT;

  // a row never written reads as all free
  assign rd_word = row_valid_r[word_r[ROW_AW-1:0]] ? ram_q : '0;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // range check terms
  assign diff = diff_r[ADDR_W-1:0];
  assign eff  = diff - ADDR_W'(bias_r);
  assign out_of_range = diff_r[ADDR_W] || (diff == '0) || (diff < ADDR_W'(bias_r))
                        || (eff >= ADDR_W'(live_count));

  // free-bit search over the current word, entries past the count count as taken
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      usable[b] = {1'b0, word_r, BIT_W'(b)} < live_count;
    end
  end

  assign taken     = rd_word | ~usable;
  assign zero_hit  = lowest_zero(taken);
  assign word_inc  = {1'b0, word_r} + (ROW_BITS + 1)'(1);
  assign next_base = {word_inc, {BIT_W{1'b0}}};
  assign bit_mask  = WORD_W'(1) << idx_r[BIT_W-1:0];
  assign cur_bit   = rd_word[idx_r[BIT_W-1:0]];

  // sequencer: next state, memory access and result
  always_comb begin
    state_nxt   = state_r;
    word_nxt    = word_r;
    idx_nxt     = idx_r;
    ram_re      = 1'b0;
    ram_raddr   = word_r[ROW_AW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = word_r[ROW_AW-1:0];
    ram_wdata   = rd_word;
    load_out    = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    res_in_use  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt  = '0;
          state_nxt = (op_t'(in_operation) == OP_REQUEST) ? S_READ : S_LOCATE;
        end
      end
      S_LOCATE: begin
        if (out_of_range) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_status = ST_OUT_OF_RANGE;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt   = eff[IDX_W-1:0];
          word_nxt  = eff[IDX_W-1:BIT_W];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (op_r)
          OP_REQUEST: begin
            if (zero_hit[BIT_W]) begin
              if (out_free) begin
                ram_we      = 1'b1;
                ram_wdata   = rd_word | (WORD_W'(1) << zero_hit[BIT_W-1:0]);
                load_out    = 1'b1;
                res_granted = base_bias_r + ADDR_W'({word_r, zero_hit[BIT_W-1:0]});
                state_nxt   = S_IDLE;
              end
            end else if (next_base < live_count) begin
              word_nxt  = word_inc[ROW_BITS-1:0];
              state_nxt = S_READ;
            end else if (out_free) begin
              load_out   = 1'b1;
              res_status = ST_EXHAUSTED;
              state_nxt  = S_IDLE;
            end
          end
          OP_FREE: begin
            if (out_free) begin
              load_out  = 1'b1;
              state_nxt = S_IDLE;
              if (!cur_bit) begin
                res_status = ST_ALREADY_FREE;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = rd_word & ~bit_mask;
              end
            end
          end
          OP_CHECK: begin
            if (out_free) begin
              load_out   = 1'b1;
              res_in_use = cur_bit;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              ram_we    = 1'b1;
              ram_wdata = new_state_r ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
              load_out  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        row_valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // item context capture
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    idx_r  <= idx_nxt;
    if (in_valid && in_ready) begin
      op_r        <= op_t'(in_operation);
      new_state_r <= in_new_state;
      diff_r      <= {1'b0, in_address} - {1'b0, base_r};
      base_bias_r <= base_r + ADDR_W'(bias_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_in_use_r  <= res_in_use;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;
  assign out_in_use          = out_in_use_r;

endmodule
